// File: sv/p16e10_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p16e10_pkg
// Shared types, constants and helpers for the posit16 ten-to-the-x pipeline.
// ----------------------------------------------------------------------------
package p16e10_pkg;

    // Special bit patterns of posit16.
    localparam logic [15:0] NAR    = 16'h8000;
    localparam logic [15:0] MINPOS = 16'h0001;
    localparam logic [15:0] MAXPOS = 16'h7FFF;
    localparam logic [15:0] ONE    = 16'h4000;

    // Range bounds that pick the special results.
    localparam logic [15:0] NEG_LARGE_HI = 16'h97DF;
    localparam logic [15:0] POS_LARGE_LO = 16'h6821;
    localparam logic [15:0] NEAR_ZERO_NEG_LO = 16'hFFA9;
    localparam logic [15:0] NEAR_ZERO_POS_HI = 16'h0077;

    // log2(10) in Q2.48, split into two 25-bit halves for the multiplier.
    localparam logic [49:0] LOG2_TEN_Q48 = 50'd935039633142894;
    localparam int unsigned HALF_W = 25;

    // Horner coefficients in Q1.31, highest degree first.
    localparam int unsigned NUM_COEF = 7;
    localparam logic [32:0] POLY_Q31 [NUM_COEF] = '{
        33'd709088, 33'd1939573, 33'd21620913, 33'd118700755,
        33'd516002500, 33'd1488510799, 33'd2147483820
    };

    // Side data that travels with each item.
    typedef struct packed {
        logic              spec;
        logic [15:0]       spec_val;
        logic signed [8:0] n;
    } t_side;

    // Length of the run of bits equal to bit 14, counted from bit 14 down.
    function automatic logic [3:0] run_len(input logic [14:0] body);
        logic [3:0] cnt;
        logic       stop;
        cnt  = 4'd0;
        stop = 1'b0;
        for (int i = 14; i >= 0; i--) begin
            if (!stop && (body[i] == body[14])) begin
                cnt = cnt + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

// File: sv/posit16_exp10_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posit16_exp10_unit
// Ten to the power of a posit16 (es=1), rounded to the nearest posit16.
// ----------------------------------------------------------------------------
//  Channel  | Valid    | Ready    | Payload
//  ---------+----------+----------+-----------------
//  input    | i_valid  | o_ready  | i_operand_posit
//  output   | o_valid  | i_ready  | o_result_posit
//
// One item enters per cycle while the output is not stalled. Each item passes
// through four front stages, six Horner multiplier stages and two encode stages.
// Reset is synchronous and active low and clears only the valid bits.
// A stall at the output freezes every stage together, so no item is lost.
// ----------------------------------------------------------------------------
module posit16_exp10_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_operand_posit,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result_posit
);

    // Whole pipeline advances unless a finished result is waiting.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Front: decode, scale by log2(10), split into n and f.
    logic                  fr_vld;
    logic [30:0]           fr_f31;
    p16e10_pkg::t_side     fr_side;

    p16e10_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_posit (i_operand_posit),
        .o_vld   (fr_vld),
        .o_f31   (fr_f31),
        .o_side  (fr_side)
    );

    // Horner chain, one stage per coefficient after the first.
    logic                  h_vld  [p16e10_pkg::NUM_COEF];
    logic [32:0]           h_y    [p16e10_pkg::NUM_COEF];
    logic [30:0]           h_f31  [p16e10_pkg::NUM_COEF];
    p16e10_pkg::t_side     h_side [p16e10_pkg::NUM_COEF];

    assign h_vld[0]  = fr_vld;
    assign h_y[0]    = p16e10_pkg::POLY_Q31[0];
    assign h_f31[0]  = fr_f31;
    assign h_side[0] = fr_side;

    for (genvar g = 1; g < p16e10_pkg::NUM_COEF; g++) begin : g_horner
        p16e10_horner_step #(
            .COEF_IDX (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (h_vld[g-1]),
            .i_y     (h_y[g-1]),
            .i_f31   (h_f31[g-1]),
            .i_side  (h_side[g-1]),
            .o_vld   (h_vld[g]),
            .o_y     (h_y[g]),
            .o_f31   (h_f31[g]),
            .o_side  (h_side[g])
        );
    end

    // Scale, round and select the special results.
    p16e10_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (h_vld[p16e10_pkg::NUM_COEF-1]),
        .i_y     (h_y[p16e10_pkg::NUM_COEF-1]),
        .i_side  (h_side[p16e10_pkg::NUM_COEF-1]),
        .o_vld   (o_valid),
        .o_posit (o_result_posit)
    );

    // The result is never zero.
    a_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_posit != 16'h0000))
        else $error("result item is zero");

    // A negative pattern out can only be NaR passed through.
    a_sign_only_nar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_posit[15]) |-> (o_result_posit == p16e10_pkg::NAR))
        else $error("negative result item other than NaR");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result item valid right after reset");

endmodule

// File: sv/p16e10_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p16e10_front
// Decodes the posit, multiplies by log2(10) and splits into n and f.
// ----------------------------------------------------------------------------
module p16e10_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [15:0]          i_posit,
    output logic                 o_vld,
    output logic [30:0]          o_f31,
    output p16e10_pkg::t_side    o_side
);

    // Stage 1: decode.
    logic              n_neg;
    logic [15:0]       n_mag;
    logic [14:0]       n_body;
    logic [3:0]        n_run;
    logic [3:0]        n_fb;
    logic              n_e;
    logic [12:0]       n_mant;
    logic signed [5:0] n_k;
    logic signed [7:0] n_d;
    logic [5:0]        n_sh;
    logic              n_spec;
    logic [15:0]       n_spec_val;

    always_comb begin
        n_neg  = i_posit[15];
        n_mag  = n_neg ? 16'(~i_posit + 16'd1) : i_posit;
        n_body = n_mag[14:0];
        n_run  = p16e10_pkg::run_len(n_body);
        if (n_run <= 4'd13) begin
            n_fb   = 4'(4'd13 - n_run);
            n_e    = n_body[n_fb];
            n_mant = (13'd1 << n_fb) | (n_body[12:0] & ((13'd1 << n_fb) - 13'd1));
        end else begin
            n_fb   = 4'd0;
            n_e    = 1'b0;
            n_mant = 13'd1;
        end
        n_k = n_body[14] ? ($signed({2'b00, n_run}) - 6'sd1) : -$signed({2'b00, n_run});
        n_d = 8'(n_k) * 8'sd2 + $signed({7'd0, n_e}) - $signed({4'd0, n_fb}) + 8'sd8;
        n_sh = (n_d > 8'sd0) ? 6'd0 : 6'(-n_d);

        // Special cases on the raw pattern.
        n_spec     = 1'b1;
        n_spec_val = p16e10_pkg::ONE;
        if (i_posit > p16e10_pkg::NAR && i_posit <= p16e10_pkg::NEG_LARGE_HI) begin
            n_spec_val = p16e10_pkg::MINPOS;
        end else if (i_posit >= p16e10_pkg::POS_LARGE_LO && i_posit < p16e10_pkg::NAR) begin
            n_spec_val = p16e10_pkg::MAXPOS;
        end else if (i_posit == p16e10_pkg::NAR) begin
            n_spec_val = p16e10_pkg::NAR;
        end else if (i_posit >= p16e10_pkg::NEAR_ZERO_NEG_LO ||
                     i_posit <= p16e10_pkg::NEAR_ZERO_POS_HI) begin
            n_spec_val = p16e10_pkg::ONE;
        end else begin
            n_spec = 1'b0;
        end
    end

    logic        r_vld1;
    logic        r_neg1;
    logic [12:0] r_mant1;
    logic [5:0]  r_sh1;
    logic        r_spec1;
    logic [15:0] r_spec_val1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1      <= n_neg;
            r_mant1     <= n_mant;
            r_sh1       <= n_sh;
            r_spec1     <= n_spec;
            r_spec_val1 <= n_spec_val;
        end
    end

    // Stage 2: two partial products of the significand and log2(10).
    logic        r_vld2;
    logic        r_neg2;
    logic [37:0] r_pl2;
    logic [37:0] r_ph2;
    logic [5:0]  r_sh2;
    logic        r_spec2;
    logic [15:0] r_spec_val2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2      <= r_neg1;
            r_pl2       <= 38'(r_mant1) * 38'(p16e10_pkg::LOG2_TEN_Q48[24:0]);
            r_ph2       <= 38'(r_mant1) * 38'(p16e10_pkg::LOG2_TEN_Q48[49:25]);
            r_sh2       <= r_sh1;
            r_spec2     <= r_spec1;
            r_spec_val2 <= r_spec_val1;
        end
    end

    // Stage 3: sum the halves and align to Q7.56.
    logic [62:0] n_t;
    logic        r_vld3;
    logic        r_neg3;
    logic [62:0] r_xp3;
    logic        r_spec3;
    logic [15:0] r_spec_val3;

    assign n_t = ({25'd0, r_ph2} << p16e10_pkg::HALF_W) + {25'd0, r_pl2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg3      <= r_neg2;
            r_xp3       <= n_t >> r_sh2;
            r_spec3     <= r_spec2;
            r_spec_val3 <= r_spec_val2;
        end
    end

    // Stage 4: integer part n and fraction f, with the sign applied.
    logic [6:0]        n_ip;
    logic [55:0]       n_fr;
    logic [55:0]       n_frn;
    logic              n_frnz;
    logic signed [8:0] n_n;
    logic [30:0]       n_f31;

    always_comb begin
        n_ip   = r_xp3[62:56];
        n_fr   = r_xp3[55:0];
        n_frn  = 56'(~n_fr + 56'd1);
        n_frnz = (n_fr != 56'd0);
        if (!r_neg3) begin
            n_n   = $signed({2'b00, n_ip});
            n_f31 = n_fr[55:25];
        end else begin
            n_n   = -$signed({2'b00, n_ip}) - $signed({8'd0, n_frnz});
            n_f31 = n_frnz ? n_frn[55:25] : 31'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_f31           <= n_f31;
            o_side.spec     <= r_spec3;
            o_side.spec_val <= r_spec_val3;
            o_side.n        <= n_n;
        end
    end

endmodule

// File: sv/p16e10_horner_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p16e10_horner_step
// One registered Horner step: y = ((y * f) >> 31) + c.
// ----------------------------------------------------------------------------
module p16e10_horner_step #(
    parameter int unsigned COEF_IDX = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [32:0]          i_y,
    input  logic [30:0]          i_f31,
    input  p16e10_pkg::t_side    i_side,
    output logic                 o_vld,
    output logic [32:0]          o_y,
    output logic [30:0]          o_f31,
    output p16e10_pkg::t_side    o_side
);

    // Product back to Q1.31, then add the coefficient.
    logic [63:0] n_prod;
    logic [32:0] n_y;

    assign n_prod = 64'(i_y) * 64'(i_f31);
    assign n_y    = n_prod[63:31] + p16e10_pkg::POLY_Q31[COEF_IDX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y    <= n_y;
            o_f31  <= i_f31;
            o_side <= i_side;
        end
    end

endmodule

// File: sv/p16e10_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p16e10_encode
// Scales 2^f by 2^n and rounds to posit16, nearest with ties to even.
// ----------------------------------------------------------------------------
module p16e10_encode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [32:0]          i_y,
    input  p16e10_pkg::t_side    i_side,
    output logic                 o_vld,
    output logic [15:0]          o_posit
);

    // Stage 1: exponent, regime and left-aligned bit string.
    logic signed [9:0] n_s;
    logic signed [9:0] n_sc;
    logic [31:0]       n_frac32;
    logic signed [5:0] n_k;
    logic [4:0]        n_rl;
    logic [63:0]       n_mask;
    logic [63:0]       n_tail;
    logic [63:0]       n_a;

    always_comb begin
        if (i_y[32]) begin
            n_s      = 10'(i_side.n) + 10'sd1;
            n_frac32 = i_y[31:0];
        end else begin
            n_s      = 10'(i_side.n);
            n_frac32 = {i_y[30:0], 1'b0};
        end
        if (n_s > 10'sd30) begin
            n_sc = 10'sd30;
        end else if (n_s < -10'sd30) begin
            n_sc = -10'sd30;
        end else begin
            n_sc = n_s;
        end
        n_k = 6'(n_sc >>> 1);
        if (n_k >= 6'sd0) begin
            n_rl   = 5'(n_k + 6'sd2);
            n_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> 5'(n_k + 6'sd1));
        end else begin
            n_rl   = 5'(6'sd1 - n_k);
            n_mask = 64'h8000_0000_0000_0000 >> 5'(-n_k);
        end
        n_tail = {n_sc[0], n_frac32, 31'd0};
        n_a    = n_mask | (n_tail >> n_rl);
    end

    logic        r_vld1;
    logic [63:0] r_a1;
    logic        r_spec1;
    logic [15:0] r_spec_val1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1        <= n_a;
            r_spec1     <= i_side.spec;
            r_spec_val1 <= i_side.spec_val;
        end
    end

    // Stage 2: round, clamp to the posit range and merge special results.
    logic [14:0] n_keep;
    logic [48:0] n_rem;
    logic        n_up;
    logic [15:0] n_rnd;
    logic [15:0] n_res;

    always_comb begin
        n_keep = r_a1[63:49];
        n_rem  = r_a1[48:0];
        n_up   = (n_rem > {1'b1, 48'd0}) || ((n_rem == {1'b1, 48'd0}) && n_keep[0]);
        n_rnd  = {1'b0, n_keep} + {15'd0, n_up};
        if (n_rnd > p16e10_pkg::MAXPOS) begin
            n_res = p16e10_pkg::MAXPOS;
        end else if (n_rnd == 16'd0) begin
            n_res = p16e10_pkg::MINPOS;
        end else begin
            n_res = n_rnd;
        end
        if (r_spec1) begin
            n_res = r_spec_val1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_posit <= n_res;
        end
    end

endmodule
